@@ rtl/core/ahob_pkg.sv @@
// Package with constants, types and the sine table for the additive oscillator bank.
package ahob_pkg;

   localparam int NUM_OSC           = 16;
   localparam int SINE_TABLE_DEPTH  = 1024;
   localparam int PHASE_BITS        = 32;
   localparam int MASK_BITS         = 16;
   localparam int GAIN_BITS         = 15;
   localparam int STEP_BITS         = 28;
   localparam int SAMPLE_BITS       = 16;
   localparam int CSR_DATA_BITS     = 16;
   localparam int CSR_INDEX_BITS    = 1;

   localparam int SINE_IDX_BITS     = $clog2(SINE_TABLE_DEPTH);
   localparam int OSC_IDX_BITS      = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1;
   localparam int PROD_BITS         = SAMPLE_BITS + GAIN_BITS + 1;
   localparam int SUM_BITS          = PROD_BITS + OSC_IDX_BITS + 1;
   localparam int STEP_SHL          = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
   localparam int STEP_SHR          = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MASK_IDX = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_IDX = 1'b1;

   localparam logic [MASK_BITS-1:0] MASK_RESET = 16'hAAAA;
   localparam logic [GAIN_BITS-1:0] GAIN_RESET = 15'd2048;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

   typedef logic signed [SAMPLE_BITS-1:0] sine_rom_type [SINE_TABLE_DEPTH];

   // Sine of a Q0.32 fraction of a cycle by a Taylor series on the first quadrant.
   function automatic logic signed [SAMPLE_BITS-1:0] sine_of_fraction(input logic [63:0] frac);
      logic [1:0]         quad;
      logic [63:0]        r;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        t;
      logic [63:0]        mag;
      logic signed [63:0] acc;
      int                 n;
      quad = frac[31:30];
      r    = frac & (ONE_Q30 - 64'd1);
      if (quad[0]) begin
         r = ONE_Q30 - r;
      end
      x    = (r * HALF_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      acc  = signed'(x);
      term = x;
      for (n = 1; n <= 8; n++) begin
         t = (term * x2) >> 30;
         case (n)
            1: term = t / 64'd6;
            2: term = t / 64'd20;
            3: term = t / 64'd42;
            4: term = t / 64'd72;
            5: term = t / 64'd110;
            6: term = t / 64'd156;
            7: term = t / 64'd210;
            8: term = t / 64'd272;
            default: term = t;
         endcase
         if (n % 2 == 1) begin
            acc = acc - signed'(term);
         end else begin
            acc = acc + signed'(term);
         end
      end
      if (acc < 0) begin
         acc = 64'sd0;
      end
      mag = (unsigned'(acc) * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
      if (mag > 64'd32767) begin
         mag = 64'd32767;
      end
      if (quad[1]) begin
         mag = -mag;
      end
      return mag[SAMPLE_BITS-1:0];
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      int           i;
      for (i = 0; i < SINE_TABLE_DEPTH; i++) begin
         rom[i] = sine_of_fraction((64'(i) << 32) / SINE_TABLE_DEPTH);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

@@ rtl/core/additive_harmonic_oscillator_bank_unit.sv @@
// Additive oscillator bank: one shared phase adder, sine ROM and multiplier over all oscillators.
// An accepted word gives its sample once the sequencer has stepped every oscillator, one per
// cycle, through the adder, ROM and multiplier, and the last product has been summed.
// A new word is taken only when idle; a waiting sample stalls the drain and so blocks input.
// Reset clears all oscillator phases, loads the default mask and gain, and empties the output.
module additive_harmonic_oscillator_bank_unit
   import ahob_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [STEP_BITS-1:0]          req_base_step,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   input  logic                          csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_write_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   localparam logic [OSC_IDX_BITS-1:0] OSC_LAST = OSC_IDX_BITS'(NUM_OSC - 1);

   logic [1:0]                    state_ff, state_in;
   logic [OSC_IDX_BITS-1:0]       osc_ff, osc_in;
   logic [PHASE_BITS-1:0]         inc_ff, inc_in;
   logic [PHASE_BITS-1:0]         kinc_ff, kinc_in;
   logic [PHASE_BITS-1:0]         phase_ff [NUM_OSC];
   logic [PHASE_BITS-1:0]         phase_sum;
   logic                          osc_enable;
   logic [MASK_BITS-1:0]          mask_shift;
   logic signed [SAMPLE_BITS-1:0] rom_q_ff;
   logic                          vb_ff, vb_in;
   logic signed [PROD_BITS-1:0]   prod_ff;
   logic                          vc_ff;
   logic signed [SUM_BITS-1:0]    sum_ff, sum_in;
   logic signed [SUM_BITS-1:0]    biased;
   logic signed [SUM_BITS-16:0]   rounded;
   logic signed [SAMPLE_BITS-1:0] sat_sample;
   logic [MASK_BITS-1:0]          mask_ff;
   logic [GAIN_BITS-1:0]          gain_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic                          req_accept;
   logic                          finish;
   logic [63:0]                   step_ext;

   assign req_stall      = (state_ff != ST_IDLE);
   assign req_accept     = req_valid && !req_stall;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;

   assign step_ext   = 64'(req_base_step);
   assign mask_shift = mask_ff >> osc_ff;
   assign osc_enable = mask_shift[0];
   assign phase_sum  = phase_ff[osc_ff] + kinc_ff;
   assign finish     = (state_ff == ST_DRAIN) && !vb_ff && !vc_ff
                       && (!rsp_valid_ff || !rsp_stall);

   assign biased  = sum_ff + SUM_BITS'(1 << 14);
   assign rounded = biased[SUM_BITS-1:15];

   always_comb begin
      if (rounded > (SUM_BITS - 15)'(32767)) begin
         sat_sample = 16'sh7FFF;
      end else if (rounded < -(SUM_BITS - 15)'(32768)) begin
         sat_sample = 16'sh8000;
      end else begin
         sat_sample = rounded[SAMPLE_BITS-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      osc_in       = osc_ff;
      inc_in       = inc_ff;
      kinc_in      = kinc_ff;
      vb_in        = 1'b0;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (vc_ff) begin
         sum_in = sum_ff + SUM_BITS'(prod_ff);
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_RUN;
               osc_in   = '0;
               inc_in   = PHASE_BITS'((step_ext << STEP_SHL) >> STEP_SHR);
               kinc_in  = '0;
               sum_in   = '0;
            end
         end
         ST_RUN: begin
            vb_in   = osc_enable;
            kinc_in = kinc_ff + inc_ff;
            osc_in  = OSC_IDX_BITS'(osc_ff + 1'b1);
            if (osc_ff == OSC_LAST) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (finish) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vb_ff        <= 1'b0;
         vc_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mask_ff      <= MASK_RESET;
         gain_ff      <= GAIN_RESET;
         for (int i = 0; i < NUM_OSC; i++) begin
            phase_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         vb_ff        <= vb_in;
         vc_ff        <= vb_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MASK_IDX: mask_ff <= csr_write_data[MASK_BITS-1:0];
               CSR_GAIN_IDX: gain_ff <= csr_write_data[GAIN_BITS-1:0];
               default: ;
            endcase
         end
         if ((state_ff == ST_RUN) && osc_enable) begin
            phase_ff[osc_ff] <= phase_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      osc_ff   <= osc_in;
      inc_ff   <= inc_in;
      kinc_ff  <= kinc_in;
      sum_ff   <= sum_in;
      rom_q_ff <= SINE_ROM[phase_sum[PHASE_BITS-1 -: SINE_IDX_BITS]];
      prod_ff  <= PROD_BITS'(rom_q_ff * signed'({1'b0, gain_ff}));
      if (finish) begin
         rsp_sample_ff <= sat_sample;
      end
   end

   a_accept_starts_run: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_RUN) && (osc_ff == '0) && (kinc_ff == '0))
      else $error("accepted word did not start the oscillator sweep");

   a_run_steps_oscillator: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) && (osc_ff != OSC_LAST)
      |=> (state_ff == ST_RUN) && (osc_ff == OSC_IDX_BITS'($past(osc_ff) + 1'b1)))
      else $error("sequencer skipped or repeated an oscillator");

   a_no_pending_product_when_idle: assert property (@(posedge clock) disable iff (reset)
      (vb_ff || vc_ff) |-> (state_ff != ST_IDLE))
      else $error("sample released while a product was still in flight");

endmodule
